[rtl/phf_pkg.sv]
// Shared types, constants and functions of the packet header filter.
// No dependencies; the top level, phf_front, phf_cell and phf_back refer to it by scoped names.
package phf_pkg;

   localparam int unsigned HashBytes   = 18;
   localparam int unsigned StreamBits  = 8 * HashBytes;
   localparam int unsigned TagBytes    = 15;
   localparam int unsigned TagBits     = 8 * TagBytes;
   localparam int unsigned CsrAddrBits = 4;
   localparam int unsigned CsrDataBits = 64;

   localparam logic [63:0] FnvBasis    = 64'hCBF2_9CE4_8422_2325;
   localparam logic [15:0] MinLength   = 16'd18;
   localparam logic        CsrMagicIdx = 1'b0;

   typedef struct packed {
      logic               need_hash;
      logic               known_acc;
      logic               pass;
      logic [TagBits-1:0] hdr;
   } phf_side_type;

   typedef struct packed {
      logic                  valid;
      logic [63:0]           hash;
      logic [StreamBits-1:0] stream;
      phf_side_type          side;
   } phf_stage_type;

   typedef struct packed {
      logic accept;
      logic passthrough;
   } phf_rsp_type;

   // One FNV-1a byte step; prime is 2^40 + 0x1B3, taken as shifts and adds.
   function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'h0, b};
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

   // Header bytes 1..17 packed, byte 1 at bits 7:0.
   function automatic logic basic_ok(input logic [135:0] d);
      logic ok;
      ok = (d[15:8] == (8'h01 | (~d[7:0] ^ 8'd113)));
      ok = ok && (d[23:16]   inside {[8'h2A:8'h2D]});
      ok = ok && (d[31:24]   inside {[8'hC8:8'hE7]});
      ok = ok && (d[39:32]   inside {[8'h05:8'h44]});
      ok = ok && (d[55:48]   inside {[8'h4E:8'h51]});
      ok = ok && (d[63:56]   inside {[8'h60:8'hDF]});
      ok = ok && (d[71:64]   inside {[8'h64:8'hE3]});
      ok = ok && (d[79:72]   inside {8'h07, 8'h4F});
      ok = ok && (d[87:80]   inside {8'h25, 8'h53});
      ok = ok && (d[95:88]   inside {[8'h7C:8'h83]});
      ok = ok && (d[103:96]  inside {[8'hAF:8'hB6]});
      ok = ok && (d[111:104] inside {[8'h21:8'h60]});
      ok = ok && (d[119:112] inside {8'h61, 8'h05, 8'h2B, 8'h0D});
      ok = ok && (d[127:120] inside {[8'hD2:8'hF1]});
      ok = ok && (d[135:128] inside {[8'h11:8'h90]});
      return ok;
   endfunction

   // Two-byte byte-sum tag, first tag byte at bits 7:0.
   function automatic logic [15:0] sum_tag(input logic [31:0] src, input logic [31:0] dst,
                                           input logic [15:0] len);
      logic [11:0] s;
      logic [7:0]  t0;
      logic [7:0]  t1;
      s = 12'(len[7:0]) + 12'(len[15:8]);
      for (int i = 0; i < 4; i++) begin
         s = s + 12'(src[8*i +: 8]) + 12'(dst[8*i +: 8]);
      end
      t0 = 8'h01 | (s[7:0] ^ {4'h0, s[11:8]} ^ 8'd193);
      t1 = 8'h01 | (~t0 ^ 8'd113);
      return {t1, t0};
   endfunction

   // Fifteen tag bytes drawn from the hash, matched against header bytes 3..17.
   function automatic logic [TagBits-1:0] hash_tag(input logic [63:0] h);
      logic [TagBits-1:0] t;
      logic [7:0]         sel_byte;
      case (h[9:8])
         2'd0:    sel_byte = 8'd97;
         2'd1:    sel_byte = 8'd5;
         2'd2:    sel_byte = 8'd43;
         default: sel_byte = 8'd13;
      endcase
      t[7:0]     = {6'h0, h[55:54]} + 8'd42;
      t[15:8]    = {3'h0, h[28:24]} + 8'd200;
      t[23:16]   = {2'h0, h[23:18]} + 8'd5;
      t[31:24]   = h[7:0];
      t[39:32]   = {6'h0, h[17:16]} + 8'd78;
      t[47:40]   = {1'b0, h[38:32]} + 8'd96;
      t[55:48]   = {2'h0, h[15:10]} + 8'd100;
      t[63:56]   = h[56] ? 8'd7 : 8'd79;
      t[71:64]   = h[39] ? 8'd83 : 8'd37;
      t[79:72]   = {5'h0, h[42:40]} + 8'd124;
      t[87:80]   = {5'h0, h[15:13]} + 8'd175;
      t[95:88]   = {2'h0, h[53:48]} + 8'd33;
      t[103:96]  = sel_byte;
      t[111:104] = {3'h0, h[47:43]} + 8'd210;
      t[119:112] = {1'b0, h[63:57]} + 8'd17;
      return t;
   endfunction

endpackage

[rtl/phf_if.sv]
// Valid/ready channel interfaces for filter requests and verdicts.
// Depends on no other file.
interface phf_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [7:0]  header_type;
   logic [15:0] pittle_bytes;
   logic [63:0] chonkle_low;
   logic [55:0] chonkle_high;
   logic [31:0] source_ipv4;
   logic [31:0] dest_ipv4;
   logic [15:0] pkt_len;

   modport source (output valid, mode, header_type, pittle_bytes, chonkle_low, chonkle_high,
                   source_ipv4, dest_ipv4, pkt_len, input ready);
   modport sink (input valid, mode, header_type, pittle_bytes, chonkle_low, chonkle_high,
                 source_ipv4, dest_ipv4, pkt_len, output ready);
endinterface

interface phf_rsp_if;
   logic valid;
   logic ready;
   logic accept;
   logic passthrough;

   modport source (output valid, accept, passthrough, input ready);
   modport sink (input valid, accept, passthrough, output ready);
endinterface

[rtl/packet_header_filter_top.sv]
// Packet header filter: one verdict per UDP header, from a chain of FNV-1a cells.
// Depends on phf_pkg, phf_if, phf_front, phf_cell and phf_back.
//
// Usage
//  - req_bus carries one header per transfer: mode, the first 18 header bytes,
//    both IPv4 addresses and the packet length.
//  - rsp_bus returns accept and passthrough for each header, in order.
//  - csr_* is an APB port holding magic_key at address 0; change it only while
//    no header is in flight.
//  - The verdict passes one entry stage, 18 hash cells (one byte of the hashed
//    stream each) and the output register.
//  - Throughput: one header per cycle while the skid register is empty; every
//    cell hands on its byte step whenever the chain advances, so the entry stage
//    and the cells hold up to 19 headers at once.
//  - Reset (synchronous, active high) empties the chain and the output stage
//    and clears magic_key to zero.
//  - When the receiver stalls with a verdict waiting and a further one arrives,
//    a skid register catches it and the whole chain holds; req_bus.ready drops
//    once the skid register is loaded and rises again once it has drained.
module packet_header_filter_top (
   input  logic                               clock,
   input  logic                               reset,
   phf_req_if.sink                            req_bus,
   phf_rsp_if.source                          rsp_bus,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [phf_pkg::CsrAddrBits-1:0]    csr_paddr,
   input  logic [phf_pkg::CsrDataBits-1:0]    csr_pwdata,
   output logic [phf_pkg::CsrDataBits-1:0]    csr_prdata,
   output logic                               csr_pready
);

   localparam int unsigned AddrIdxBit = phf_pkg::CsrAddrBits - 1;

   logic [63:0]            magic_ff, magic_in;
   logic                   advance;
   logic                   csr_write;
   phf_pkg::phf_stage_type chain [phf_pkg::HashBytes+1];
   phf_pkg::phf_rsp_type   rsp_data;

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[AddrIdxBit] == phf_pkg::CsrMagicIdx);

   always_comb begin
      magic_in = magic_ff;
      if (csr_write) begin
         magic_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= '0;
      end else begin
         magic_ff <= magic_in;
      end
   end

   assign csr_prdata = (csr_paddr[AddrIdxBit] == phf_pkg::CsrMagicIdx) ? magic_ff : '0;

   assign req_bus.ready = advance;

   phf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .en            (advance),
      .in_valid      (req_bus.valid),
      .mode          (req_bus.mode),
      .header_type   (req_bus.header_type),
      .pittle_bytes  (req_bus.pittle_bytes),
      .chonkle_low   (req_bus.chonkle_low),
      .chonkle_high  (req_bus.chonkle_high),
      .source_ipv4   (req_bus.source_ipv4),
      .dest_ipv4     (req_bus.dest_ipv4),
      .pkt_len       (req_bus.pkt_len),
      .magic_key     (magic_ff),
      .stage_out     (chain[0])
   );

   for (genvar i = 0; i < phf_pkg::HashBytes; i++) begin : g_cell
      phf_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (advance),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   phf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .stage_in  (chain[phf_pkg::HashBytes]),
      .advance   (advance),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_bus.accept      = rsp_data.accept;
   assign rsp_bus.passthrough = rsp_data.passthrough;

endmodule

[rtl/phf_front.sv]
// Entry stage: decodes the header, settles every verdict that needs no hash
// and loads the byte stream for the hash chain. Depends on phf_pkg.
module phf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic                  mode,
   input  logic [7:0]            header_type,
   input  logic [15:0]           pittle_bytes,
   input  logic [63:0]           chonkle_low,
   input  logic [55:0]           chonkle_high,
   input  logic [31:0]           source_ipv4,
   input  logic [31:0]           dest_ipv4,
   input  logic [15:0]           pkt_len,
   input  logic [63:0]           magic_key,
   output phf_pkg::phf_stage_type stage_out
);

   phf_pkg::phf_stage_type stage_ff;
   phf_pkg::phf_stage_type stage_in;
   logic [135:0]           hdr_bytes;
   logic                   sum_ok;

   always_comb begin
      hdr_bytes = {chonkle_high, chonkle_low, pittle_bytes};
      sum_ok    = (pittle_bytes == phf_pkg::sum_tag(source_ipv4, dest_ipv4, pkt_len));

      stage_in                = '0;
      stage_in.valid          = in_valid;
      stage_in.hash           = phf_pkg::FnvBasis;
      stage_in.stream         = {pkt_len, dest_ipv4, source_ipv4, magic_key};
      stage_in.side.hdr       = {chonkle_high, chonkle_low};

      if (!mode && pkt_len == 16'h0) begin
         stage_in.side.known_acc = 1'b0;
      end else if (header_type == 8'h00) begin
         stage_in.side.known_acc = 1'b1;
         stage_in.side.pass      = 1'b1;
      end else if (pkt_len < phf_pkg::MinLength) begin
         stage_in.side.known_acc = 1'b0;
      end else if (!mode) begin
         stage_in.side.known_acc = phf_pkg::basic_ok(hdr_bytes);
      end else begin
         // reject at once on a bad sum tag, else defer to the hash compare
         stage_in.side.need_hash = sum_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

[rtl/phf_cell.sv]
// One cell of the hash chain: folds the lowest stream byte into the hash
// and hands hash, remaining stream and verdict data on. Depends on phf_pkg.
module phf_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  phf_pkg::phf_stage_type stage_in,
   output phf_pkg::phf_stage_type stage_out
);

   phf_pkg::phf_stage_type stage_ff;
   phf_pkg::phf_stage_type stage_next_in;

   always_comb begin
      stage_next_in        = stage_in;
      stage_next_in.hash   = phf_pkg::fnv_step(stage_in.hash, stage_in.stream[7:0]);
      stage_next_in.stream = {8'h00, stage_in.stream[phf_pkg::StreamBits-1:8]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_next_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

[rtl/phf_back.sv]
// Exit stage: compares the hash tag, forms the verdict and holds it in an
// output register backed by a skid register. Depends on phf_pkg.
module phf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  phf_pkg::phf_stage_type stage_in,
   output logic                  advance,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output phf_pkg::phf_rsp_type  rsp_data
);

   phf_pkg::phf_rsp_type verdict;
   phf_pkg::phf_rsp_type out_data_ff, out_data_in;
   phf_pkg::phf_rsp_type skid_data_ff, skid_data_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   logic                 taken;
   logic                 tag_match;

   always_comb begin
      tag_match           = (phf_pkg::hash_tag(stage_in.hash) == stage_in.side.hdr);
      verdict.accept      = stage_in.side.need_hash ? tag_match : stage_in.side.known_acc;
      verdict.passthrough = stage_in.side.pass;
   end

   assign advance = !skid_valid_ff;
   assign taken   = out_valid_ff && rsp_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // chain is held; drain the skid once the output frees up
         if (taken) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (stage_in.valid) begin
         if (!out_valid_ff || taken) begin
            out_valid_in = 1'b1;
            out_data_in  = verdict;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = verdict;
         end
      end else if (taken) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[rtl/phf_checker.sv]
// Port-level checks on the packet header filter, bound to the top level.
// Depends on packet_header_filter_top and its channel interfaces.
module phf_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_accept,
   input logic rsp_passthrough
);

   // a verdict offered must stay offered until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("verdict withdrawn before transfer");

   a_pass_accepts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_passthrough |-> rsp_accept)
      else $error("passthrough without accept");

   // intake only stops while a verdict is waiting at the output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("intake held with no pending verdict");

   a_stall_start: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(rsp_valid && !rsp_ready))
      else $error("intake held without a receiver stall");

endmodule

bind packet_header_filter_top phf_checker u_phf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_accept      (rsp_bus.accept),
   .rsp_passthrough (rsp_bus.passthrough)
);
